/* src/dcts_pkg.sv */
// ----------------------------------------------------------------------------
// dcts_pkg
// Shared constants and helpers for the DRAM cache tag store.
// ----------------------------------------------------------------------------
package dcts_pkg;

	// Default geometry
	localparam int DEF_SETS_MAX         = 1024;
	localparam int DEF_WAYS_MAX         = 8;
	localparam int DEF_LINE_OFFSET_BITS = 6;
	localparam int DEF_ADDR_BITS        = 48;

	// Fixed field widths
	localparam int CADDR_W    = 19;
	localparam int CNT_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SET_INDEX_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE    = 2'd1;

	// Configuration reset values (before saturation)
	localparam int RST_SET_INDEX_BITS = 10;
	localparam int RST_WAYS_IN_USE    = 8;

	// Request codes
	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_FILL   = 1'b1;

	// floor(log2(n)) for n >= 1, capped at 16
	function automatic int floor_log2(input int n);
		int b;
		b = 0;
		while (b < 16 && (2 ** (b + 1)) <= n)
			b++;
		return b;
	endfunction

endpackage

/* src/dcts_tag_ram.sv */
// ----------------------------------------------------------------------------
// dcts_tag_ram
// One-row-per-set tag and valid memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module dcts_tag_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 344
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// read-during-write to the same row returns the old contents
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

/* src/dcts_way_logic.sv */
// ----------------------------------------------------------------------------
// dcts_way_logic
// Way compare for lookups and FIFO row update for fills on one set row.
// ----------------------------------------------------------------------------
module dcts_way_logic #(
	parameter int WAYS_MAX = 8,
	parameter int TAG_W    = 42,
	parameter int NW_W     = 4,
	parameter int WAY_W    = 3
) (
	input  logic                            func,
	input  logic [TAG_W-1:0]                tag,
	input  logic [NW_W-1:0]                 nw,
	input  logic [WAYS_MAX-1:0]             valid_in,
	input  logic [WAYS_MAX-1:0][TAG_W-1:0]  tags_in,
	output logic                            hit,
	output logic [WAY_W-1:0]                way,
	output logic                            wr,
	output logic [WAYS_MAX-1:0]             valid_out,
	output logic [WAYS_MAX-1:0][TAG_W-1:0]  tags_out
);

	import dcts_pkg::*;

	logic full;
	logic found;

	always_comb begin
		full = 1'b1;
		for (int w = 0; w < WAYS_MAX; w++)
			if (w < int'(nw) && !valid_in[w])
				full = 1'b0;

		hit       = 1'b0;
		found     = 1'b0;
		way       = WAY_W'(nw - NW_W'(1));
		wr        = 1'b0;
		valid_out = valid_in;
		tags_out  = tags_in;

		if (func == FUNC_LOOKUP) begin
			// lowest matching way wins
			for (int w = 0; w < WAYS_MAX; w++) begin
				if (!found && w < int'(nw) && valid_in[w] && tags_in[w] == tag) begin
					found = 1'b1;
					way   = WAY_W'(w);
				end
			end
			hit = found;
		end else begin
			wr = 1'b1;
			if (full) begin
				// drop way 0, shift the rest down, refill the last way in use
				for (int w = 0; w < WAYS_MAX - 1; w++) begin
					if (w + 1 < int'(nw)) begin
						valid_out[w] = valid_in[w + 1];
						tags_out[w]  = tags_in[w + 1];
					end
				end
			end else begin
				for (int w = 0; w < WAYS_MAX; w++) begin
					if (!found && w < int'(nw) && !valid_in[w]) begin
						found = 1'b1;
						way   = WAY_W'(w);
					end
				end
			end
			valid_out[way] = 1'b1;
			tags_out[way]  = tag;
		end
	end

endmodule

/* src/dram_cache_tag_store.sv */
// ----------------------------------------------------------------------------
// dram_cache_tag_store
// Set-associative DRAM cache tag store with FIFO replacement.
// ----------------------------------------------------------------------------
// One request per cycle is accepted unless the output register is stalled by
// out_ready: each takes one read of its set's row (all ways' tags and valid
// bits) from the tag memory, a way compare, and, for a fill, a write-back of
// the row; a row-forwarding register covers a request that reads the set just
// written. A request is registered in the lookup stage, its result in the
// output register. After reset a clearing pass zeroes the valid bits, during
// which no request is taken; configuration writes are taken at any time.
module dram_cache_tag_store #(
	parameter int SETS_MAX         = dcts_pkg::DEF_SETS_MAX,
	parameter int WAYS_MAX         = dcts_pkg::DEF_WAYS_MAX,
	parameter int LINE_OFFSET_BITS = dcts_pkg::DEF_LINE_OFFSET_BITS,
	parameter int ADDR_BITS        = dcts_pkg::DEF_ADDR_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dcts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dcts_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               func,
	input  logic [ADDR_BITS-1:0]               phys_address,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               hit,
	output logic [dcts_pkg::CADDR_W-1:0]       cache_address,
	output logic [dcts_pkg::CNT_W-1:0]         hit_count,
	output logic [dcts_pkg::CNT_W-1:0]         miss_count
);

	import dcts_pkg::*;

	localparam int MAX_IB = floor_log2(SETS_MAX);
	localparam int IDX_W  = (SETS_MAX > 1) ? $clog2(SETS_MAX) : 1;
	localparam int WAY_W  = (WAYS_MAX > 1) ? $clog2(WAYS_MAX) : 1;
	localparam int NW_W   = $clog2(WAYS_MAX + 1);
	localparam int IB_W   = (MAX_IB > 0) ? $clog2(MAX_IB + 1) : 1;
	localparam int TAG_W  = ADDR_BITS - LINE_OFFSET_BITS;
	localparam int TS_W   = $clog2(MAX_IB + LINE_OFFSET_BITS + 1);
	localparam int ROW_W  = WAYS_MAX * (TAG_W + 1);
	localparam int RST_IB = (RST_SET_INDEX_BITS > MAX_IB) ? MAX_IB : RST_SET_INDEX_BITS;
	localparam int RST_NW = (RST_WAYS_IN_USE > WAYS_MAX) ? WAYS_MAX : RST_WAYS_IN_USE;
	localparam int CW_W   = 6;

	// configuration
	logic [IB_W-1:0]  ib_q;
	logic [NW_W-1:0]  nw_q;
	logic [CW_W-1:0]  cfg_wide;

	// clearing pass
	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_cnt_q;

	// request decode
	logic [IDX_W-1:0] set_mask;
	logic [IDX_W-1:0] in_set;
	logic [TS_W-1:0]  tshift;
	logic [TAG_W-1:0] in_tag;
	logic             in_fire;
	logic             adv;

	// lookup stage
	logic             valid_s1;
	logic             func_s1;
	logic [IDX_W-1:0] set_s1;
	logic [TAG_W-1:0] tag_s1;

	// memory
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [ROW_W-1:0] mem_wdata;
	logic [ROW_W-1:0] mem_rdata;
	logic [ROW_W-1:0] row;

	// forwarding of the last row written
	logic             fwd_valid_q;
	logic [IDX_W-1:0] fwd_set_q;
	logic [ROW_W-1:0] fwd_row_q;

	// way logic
	logic                           wl_hit;
	logic [WAY_W-1:0]               wl_way;
	logic                           wl_wr;
	logic [WAYS_MAX-1:0]            wl_valid;
	logic [WAYS_MAX-1:0][TAG_W-1:0] wl_tags;
	logic [CADDR_W-1:0]             caddr_next;

	// result register and counters
	logic               out_valid_q;
	logic               hit_q;
	logic [CADDR_W-1:0] caddr_q;
	logic [CNT_W-1:0]   hit_cnt_q;
	logic [CNT_W-1:0]   miss_cnt_q;

	assign cfg_ready = 1'b1;
	assign cfg_wide  = CW_W'(cfg_data);

	// hold saturated values so the datapath never sees out-of-range settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ib_q <= IB_W'(RST_IB);
			nw_q <= NW_W'(RST_NW);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SET_INDEX_BITS: begin
					if (cfg_wide > CW_W'(MAX_IB))
						ib_q <= IB_W'(MAX_IB);
					else
						ib_q <= IB_W'(cfg_wide);
				end
				REG_WAYS_IN_USE: begin
					if (cfg_wide == '0)
						nw_q <= NW_W'(1);
					else if (cfg_wide > CW_W'(WAYS_MAX))
						nw_q <= NW_W'(WAYS_MAX);
					else
						nw_q <= NW_W'(cfg_wide);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_cnt_q == IDX_W'(SETS_MAX - 1))
				clr_busy_q <= 1'b0;
			else
				clr_cnt_q <= clr_cnt_q + IDX_W'(1);
		end
	end

	always_comb begin
		for (int i = 0; i < IDX_W; i++)
			set_mask[i] = (i < int'(ib_q));
		in_set = phys_address[LINE_OFFSET_BITS +: IDX_W] & set_mask;
		tshift = TS_W'(ib_q) + TS_W'(LINE_OFFSET_BITS);
		in_tag = TAG_W'(phys_address >> tshift);
	end

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !clr_busy_q && (!valid_s1 || adv);
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_fire)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_s1 <= func;
			set_s1  <= in_set;
			tag_s1  <= in_tag;
		end
	end

	always_comb begin
		if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end else begin
			mem_we    = adv && wl_wr;
			mem_waddr = set_s1;
			mem_wdata = {wl_valid, wl_tags};
		end
	end

	dcts_tag_ram #(
		.DEPTH (SETS_MAX),
		.AW    (IDX_W),
		.DW    (ROW_W)
	) u_tag_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (in_fire),
		.raddr (in_set),
		.rdata (mem_rdata)
	);

	// the latest write to a set is always the freshest copy of that row
	assign row = (fwd_valid_q && fwd_set_q == set_s1) ? fwd_row_q : mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fwd_valid_q <= 1'b0;
		else if (adv && wl_wr)
			fwd_valid_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (adv && wl_wr) begin
			fwd_set_q <= set_s1;
			fwd_row_q <= mem_wdata;
		end
	end

	dcts_way_logic #(
		.WAYS_MAX (WAYS_MAX),
		.TAG_W    (TAG_W),
		.NW_W     (NW_W),
		.WAY_W    (WAY_W)
	) u_way_logic (
		.func      (func_s1),
		.tag       (tag_s1),
		.nw        (nw_q),
		.valid_in  (row[ROW_W-1 -: WAYS_MAX]),
		.tags_in   (row[WAYS_MAX*TAG_W-1:0]),
		.hit       (wl_hit),
		.way       (wl_way),
		.wr        (wl_wr),
		.valid_out (wl_valid),
		.tags_out  (wl_tags)
	);

	assign caddr_next = (CADDR_W'(wl_way) << tshift)
		| (CADDR_W'(set_s1) << LINE_OFFSET_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
		end else begin
			if (adv)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			// counters stop at all ones
			if (adv && func_s1 == FUNC_LOOKUP) begin
				if (wl_hit) begin
					if (hit_cnt_q != '1)
						hit_cnt_q <= hit_cnt_q + CNT_W'(1);
				end else begin
					if (miss_cnt_q != '1)
						miss_cnt_q <= miss_cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q   <= wl_hit;
			caddr_q <= caddr_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign cache_address = caddr_q;
	assign hit_count     = hit_cnt_q;
	assign miss_count    = miss_cnt_q;

endmodule
